>>> rtl/bcd_pkg.sv
// Shared types, operation codes and widths for the bounded course deque.
package bcd_pkg;

    localparam int DEPTH_DEF = 16;

    // Beat layout
    localparam int KIND_W   = 3;
    localparam int REC_W    = 88;
    localparam int OCC_W    = 5;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 96;

    // Operation codes carried in s_tuser
    localparam logic [KIND_W-1:0] KIND_PUSH_TAIL = 3'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_HEAD = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PEEK      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_out;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_valid;
    } dp_status_t;

endpackage

>>> rtl/bcd_ctrl.sv
// Controller state machine: takes one beat, then hands its result to the output register.
module bcd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                m_tready,
    input  bcd_pkg::dp_status_t status,
    output bcd_pkg::ctrl_cmd_t  cmd
);
    import bcd_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // wait until the output register is free or being drained
                if (!status.out_valid || m_tready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/bcd_datapath.sv
// Datapath: circular buffer memory, head and fill pointers, result staging and output register.
module bcd_datapath #(
    parameter int DEPTH = bcd_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [bcd_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [bcd_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bcd_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tuser,
    input  bcd_pkg::ctrl_cmd_t            cmd,
    output bcd_pkg::dp_status_t           status
);
    import bcd_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 2;

    logic [REC_W-1:0] mem [DEPTH];
    logic [REC_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;

    logic             ok_pend_reg;
    logic             ok_next;
    logic             show_pend_reg;
    logic             show_next;
    logic [OCC_W-1:0] occ_pend_reg;

    logic             out_valid_reg;
    logic             out_ok_reg;
    logic [REC_W-1:0] out_rec_reg;
    logic [OCC_W-1:0] out_occ_reg;

    logic                   full;
    logic                   empty;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       head_inc;
    logic [IDX_W-1:0]       head_dec;
    logic [IDX_W-1:0]       tail_idx;
    logic [SUM_W-1:0]       tail_sum;

    assign full  = (fill_reg == CNT_W'(DEPTH));
    assign empty = (fill_reg == '0);

    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + IDX_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);

    // head + fill stays below twice the depth, so one subtract wraps it
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
    assign tail_idx = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                  : IDX_W'(tail_sum);

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        ok_next   = 1'b0;
        show_next = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = tail_idx;
        unique case (s_tuser)
            KIND_PUSH_TAIL: begin
                if (!full) begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                    ok_next   = 1'b1;
                end
            end
            KIND_PUSH_HEAD: begin
                if (!full) begin
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    head_next = head_dec;
                    fill_next = fill_reg + CNT_W'(1);
                    ok_next   = 1'b1;
                end
            end
            KIND_POP: begin
                if (!empty) begin
                    ok_next   = 1'b1;
                    show_next = 1'b1;
                    head_next = head_inc;
                    fill_next = fill_reg - CNT_W'(1);
                end
            end
            KIND_PEEK: begin
                if (!empty) begin
                    ok_next   = 1'b1;
                    show_next = 1'b1;
                end
            end
            KIND_CLEAR: begin
                head_next = '0;
                fill_next = '0;
                ok_next   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // record store: written at one slot, read at the old head
    always_ff @(posedge aclk) begin
        if (cmd.accept && wr_en) begin
            mem[wr_addr] <= s_tdata[REC_W-1:0];
        end
        if (cmd.accept) begin
            rd_data_reg <= mem[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else if (cmd.accept) begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // occupancy is the fill count truncated or zero-extended to the field width
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ok_pend_reg   <= ok_next;
            show_pend_reg <= show_next;
            occ_pend_reg  <= OCC_W'(fill_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_ok_reg  <= ok_pend_reg;
            out_rec_reg <= show_pend_reg ? rd_data_reg : '0;
            out_occ_reg <= occ_pend_reg;
        end
    end

    assign m_tvalid         = out_valid_reg;
    assign m_tuser          = out_ok_reg;
    assign m_tdata          = {{(M_DATA_W - REC_W - OCC_W){1'b0}}, out_occ_reg, out_rec_reg};
    assign status.out_valid = out_valid_reg;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= IDX_W'(DEPTH - 1))
        else $error("head index out of range");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept && (s_tuser == KIND_CLEAR) |=> (fill_reg == '0) && (head_reg == '0))
        else $error("clear left records behind");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while held");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && cmd.load_out))
        else $error("accept and load in the same cycle");

endmodule

>>> rtl/bounded_course_deque.sv
// Top level of the bounded course deque: controller plus datapath.
//
// Bounded double-ended queue of course records kept in a circular buffer of
// DEPTH slots. Each input beat carries an operation in s_tuser (push tail,
// push head, pop, peek, clear) and, for pushes, the record in s_tdata.
// Each beat yields exactly one result beat: m_tuser is the success flag,
// m_tdata holds the head record for a successful pop or peek (else zeros)
// and the occupancy after the operation.
// The record store has a registered read port, so a beat is taken in the
// idle state and its result is loaded into the output register from the
// emit state; no new beat is taken until that result is loaded.
// A result waits in the output register while m_tready is low; the block
// then holds s_tready low after the next beat until that register drains.
// Reset empties the queue and drops any pending result; record slots keep
// their contents, and only written slots are ever read back.
module bounded_course_deque #(
    parameter int DEPTH = bcd_pkg::DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // station[15:0] speed[23:16] node_id[39:24] sequence_req[47:40]
    // enqueue_time[79:48] record_flags[87:80]
    input  logic [bcd_pkg::S_DATA_W-1:0]  s_tdata,
    // kind[2:0]
    input  logic [bcd_pkg::KIND_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_station[15:0] out_speed[23:16] out_node_id[39:24] out_sequence[47:40]
    // out_enqueue_time[79:48] out_flags[87:80] occupancy[92:88] zeros[95:93]
    output logic [bcd_pkg::M_DATA_W-1:0]  m_tdata,
    // ok[0]
    output logic                          m_tuser
);
    import bcd_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bcd_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
